>>> sv/rmsnorm_forward_backward_core_macros.svh
// ----------------------------------------------------------------------------
// RMSNorm core assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef RMSNORM_FORWARD_BACKWARD_CORE_MACROS_SVH
`define RMSNORM_FORWARD_BACKWARD_CORE_MACROS_SVH

// Property checked at every edge outside reset.
`define RMSNFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in the cycle after a trigger.
`define RMSNFB_ASSERT_NEXT(lbl, pre, post, msg) \
  `RMSNFB_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> sv/rmsnfb_pkg.sv
// ----------------------------------------------------------------------------
// RMSNorm core package
// Datapath commands, multiply step codes and saturation helpers.
// ----------------------------------------------------------------------------
package rmsnfb_pkg;

  localparam int unsigned DivSteps  = 48;
  localparam int unsigned SqrtSteps = 23;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_ACC2,
    OP_LOAD,
    OP_DIV_MS_INIT,
    OP_DIV_INV_INIT,
    OP_DIV_MEAN_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_INV_SET,
    OP_MEAN_SET,
    OP_MUL,
    OP_MUL_SUM,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    MS_INVW,
    MS_T1G,
    MS_XMEAN,
    MS_AINV,
    MS_BINV,
    MS_CINV,
    MS_GX,
    MS_GXINV,
    MS_XW,
    MS_YINV
  } mstep_e;

  typedef struct packed {
    op_e    op;
    mstep_e step;
  } cmd_t;

  typedef struct packed {
    logic pass2;
    logic pass_last;
    logic out_busy;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [61:0] v);
    logic signed [61:0] hi;
    logic signed [61:0] lo;
    hi = 62'sh7FFF_FFFF;
    lo = -62'sh8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [61:0] v);
    logic signed [61:0] hi;
    logic signed [61:0] lo;
    hi = 62'sh7F_FFFF_FFFF;
    lo = -62'sh80_0000_0000;
    if (v > hi) return 40'sh7F_FFFF_FFFF;
    if (v < lo) return -40'sh80_0000_0000;
    return v[39:0];
  endfunction

endpackage

>>> sv/rmsnfb_ctrl.sv
// ----------------------------------------------------------------------------
// RMSNorm controller
// Sequences accumulation, divide/sqrt iterations and per-word multiply steps.
// ----------------------------------------------------------------------------
module rmsnfb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  rmsnfb_pkg::sts_t  sts_i,
  output rmsnfb_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACC2   = 4'd1;
  localparam logic [3:0] S_DINIT  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_SQINIT = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_POST   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_MSUM   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  localparam logic [1:0] PH_MS   = 2'd0;
  localparam logic [1:0] PH_INV  = 2'd1;
  localparam logic [1:0] PH_MEAN = 2'd2;

  localparam logic [5:0] DivLast  = 6'(rmsnfb_pkg::DivSteps - 1);
  localparam logic [5:0] SqrtLast = 6'(rmsnfb_pkg::SqrtSteps - 1);

  logic [3:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic [5:0] it_q, it_d;
  rmsnfb_pkg::mstep_e step_q, step_d;

  assign in_ready_o = (st_q == S_IDLE);

  always_comb begin
    st_d        = st_q;
    ph_d        = ph_q;
    it_d        = it_q;
    step_d      = step_q;
    cmd_o.op    = rmsnfb_pkg::OP_NONE;
    cmd_o.step  = step_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.pass2) begin
            cmd_o.op = rmsnfb_pkg::OP_LOAD;
            step_d   = mode_i ? rmsnfb_pkg::MS_INVW : rmsnfb_pkg::MS_XW;
            st_d     = S_MUL;
          end else begin
            cmd_o.op = rmsnfb_pkg::OP_ACC;
            st_d     = S_ACC2;
          end
        end
      end
      S_ACC2: begin
        cmd_o.op = rmsnfb_pkg::OP_ACC2;
        if (sts_i.pass_last) begin
          ph_d = PH_MS;
          st_d = S_DINIT;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_DINIT: begin
        case (ph_q)
          PH_MS:   cmd_o.op = rmsnfb_pkg::OP_DIV_MS_INIT;
          PH_INV:  cmd_o.op = rmsnfb_pkg::OP_DIV_INV_INIT;
          default: cmd_o.op = rmsnfb_pkg::OP_DIV_MEAN_INIT;
        endcase
        it_d = '0;
        st_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = rmsnfb_pkg::OP_DIV_STEP;
        it_d     = it_q + 6'd1;
        if (it_q == DivLast) begin
          st_d = (ph_q == PH_MS) ? S_SQINIT : S_POST;
        end
      end
      S_SQINIT: begin
        cmd_o.op = rmsnfb_pkg::OP_SQRT_INIT;
        it_d     = '0;
        st_d     = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = rmsnfb_pkg::OP_SQRT_STEP;
        it_d     = it_q + 6'd1;
        if (it_q == SqrtLast) begin
          ph_d = PH_INV;
          st_d = S_DINIT;
        end
      end
      S_POST: begin
        if (ph_q == PH_INV) begin
          cmd_o.op = rmsnfb_pkg::OP_INV_SET;
          ph_d     = PH_MEAN;
          st_d     = S_DINIT;
        end else begin
          cmd_o.op = rmsnfb_pkg::OP_MEAN_SET;
          st_d     = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.op = rmsnfb_pkg::OP_MUL;
        st_d     = S_MSUM;
      end
      S_MSUM: begin
        cmd_o.op = rmsnfb_pkg::OP_MUL_SUM;
        st_d     = S_MUL;
        case (step_q)
          rmsnfb_pkg::MS_INVW:  step_d = rmsnfb_pkg::MS_T1G;
          rmsnfb_pkg::MS_T1G:   step_d = rmsnfb_pkg::MS_XMEAN;
          rmsnfb_pkg::MS_XMEAN: step_d = rmsnfb_pkg::MS_AINV;
          rmsnfb_pkg::MS_AINV:  step_d = rmsnfb_pkg::MS_BINV;
          rmsnfb_pkg::MS_BINV:  step_d = rmsnfb_pkg::MS_CINV;
          rmsnfb_pkg::MS_CINV:  step_d = rmsnfb_pkg::MS_GX;
          rmsnfb_pkg::MS_GX:    step_d = rmsnfb_pkg::MS_GXINV;
          rmsnfb_pkg::MS_XW:    step_d = rmsnfb_pkg::MS_YINV;
          default:              st_d   = S_EMIT;
        endcase
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = rmsnfb_pkg::OP_EMIT;
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ph_q   <= PH_MS;
      it_q   <= '0;
      step_q <= rmsnfb_pkg::MS_INVW;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      it_q   <= it_d;
      step_q <= step_d;
    end
  end

endmodule

>>> sv/rmsnfb_dp.sv
// ----------------------------------------------------------------------------
// RMSNorm datapath
// Accumulators, shared divider, square root, split multiplier, output stage.
// ----------------------------------------------------------------------------
`include "rmsnorm_forward_backward_core_macros.svh"

module rmsnfb_dp #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmsnfb_pkg::cmd_t    cmd_i,
  output rmsnfb_pkg::sts_t    sts_o,
  input  logic signed [15:0]  x_i,
  input  logic signed [15:0]  w_i,
  input  logic signed [15:0]  g_i,
  input  logic                mode_i,
  input  logic [12:0]         vec_len_i,
  input  logic [15:0]         eps_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic signed [31:0]  m_main_o,
  output logic signed [31:0]  m_wgrad_o,
  output logic                m_last_o
);

  localparam logic [16:0] MaxLen = 17'(MAX_LEN);

  logic [12:0]        len;
  logic               pass_last;

  logic [43:0]        sum_q;
  logic signed [47:0] mean_q;
  logic [23:0]        inv_q;
  logic [12:0]        cnt_q;
  logic               pass2_q;

  logic signed [15:0] x_q, w_q, g_q;
  logic signed [48:0] tmp_q, t1_q;
  logic signed [55:0] t2_q;
  logic signed [31:0] y_q, gw_q;

  logic [24:0]        rem_q;
  logic [47:0]        quo_q;
  logic [23:0]        dvs_q;
  logic [45:0]        sv_q, root_q, bit_q;

  logic signed [49:0] pl_q, ph_q;

  logic               m_valid_q, m_last_q;
  logic signed [31:0] m_main_q, m_wgrad_q;

  // length clamp and pass end
  always_comb begin
    len = (vec_len_i == '0) ? 13'd1 : vec_len_i;
    if (17'(vec_len_i) > MaxLen) len = MaxLen[12:0];
    pass_last = (14'(cnt_q) + 14'd1) >= 14'(len);
  end

  assign sts_o.pass2     = pass2_q;
  assign sts_o.pass_last = pass_last;
  assign sts_o.out_busy  = m_valid_q & ~m_ready_i;

  // divider step
  logic [24:0] div_r;
  logic        div_ge;
  assign div_r  = {rem_q[23:0], quo_q[47]};
  assign div_ge = div_r >= {1'b0, dvs_q};

  // sqrt step
  logic [45:0] sq_trial;
  assign sq_trial = root_q + bit_q;

  // multiplier operand select, split into two 25x25 partials
  logic signed [48:0] opa;
  logic signed [24:0] opb;
  logic signed [24:0] a_lo, a_hi;
  logic signed [49:0] pl, ph;
  always_comb begin
    case (cmd_i.step)
      rmsnfb_pkg::MS_INVW: begin
        opa = 49'(signed'({1'b0, inv_q}));
        opb = 25'(w_q);
      end
      rmsnfb_pkg::MS_T1G: begin
        opa = tmp_q;
        opb = 25'(g_q);
      end
      rmsnfb_pkg::MS_XMEAN: begin
        opa = 49'(mean_q);
        opb = 25'(x_q);
      end
      rmsnfb_pkg::MS_GX: begin
        opa = 49'(g_q);
        opb = 25'(x_q);
      end
      rmsnfb_pkg::MS_XW: begin
        opa = 49'(x_q);
        opb = 25'(w_q);
      end
      default: begin
        opa = tmp_q;
        opb = signed'({1'b0, inv_q});
      end
    endcase
    a_lo = signed'({1'b0, opa[23:0]});
    a_hi = opa[48:24];
    pl   = a_lo * opb;
    ph   = a_hi * opb;
  end

  logic [73:0]        prod;
  logic signed [61:0] p12;
  logic signed [49:0] p24;
  logic signed [61:0] gx_diff;
  assign prod    = {ph_q, 24'd0} + {{24{pl_q[49]}}, pl_q};
  assign p12     = signed'(prod[73:12]);
  assign p24     = signed'(prod[73:24]);
  assign gx_diff = 62'(t1_q) - 62'(t2_q);

  logic [47:0] mean_abs;
  assign mean_abs = mean_q[47] ? 48'(-mean_q) : 48'(mean_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      mean_q  <= '0;
      inv_q   <= '0;
      cnt_q   <= '0;
      pass2_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        rmsnfb_pkg::OP_ACC: begin
          sum_q <= sum_q + 44'(unsigned'(32'(x_i) * 32'(x_i)));
        end
        rmsnfb_pkg::OP_ACC2: begin
          mean_q <= mean_q + 48'(signed'(tmp_q[19:0])) * 48'(x_q);
          cnt_q  <= pass_last ? 13'd0 : cnt_q + 13'd1;
        end
        rmsnfb_pkg::OP_INV_SET: begin
          inv_q <= (|quo_q[47:24]) ? 24'hFF_FFFF : quo_q[23:0];
        end
        rmsnfb_pkg::OP_MEAN_SET: begin
          mean_q  <= mean_q[47] ? -signed'(quo_q) : signed'(quo_q);
          pass2_q <= 1'b1;
        end
        rmsnfb_pkg::OP_EMIT: begin
          if (pass_last) begin
            sum_q   <= '0;
            mean_q  <= '0;
            inv_q   <= '0;
            cnt_q   <= '0;
            pass2_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 13'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rmsnfb_pkg::OP_ACC: begin
        x_q   <= x_i;
        tmp_q <= 49'((32'(g_i) * 32'(w_i)) >>> 12);
      end
      rmsnfb_pkg::OP_LOAD: begin
        x_q <= x_i;
        w_q <= w_i;
        g_q <= g_i;
      end
      rmsnfb_pkg::OP_DIV_MS_INIT: begin
        rem_q <= '0;
        quo_q <= 48'(sum_q);
        dvs_q <= 24'(len);
      end
      rmsnfb_pkg::OP_DIV_INV_INIT: begin
        rem_q <= '0;
        quo_q <= 48'h00_0001_00_0000;
        dvs_q <= root_q[23:0];
      end
      rmsnfb_pkg::OP_DIV_MEAN_INIT: begin
        rem_q <= '0;
        quo_q <= mean_abs;
        dvs_q <= 24'(len);
      end
      rmsnfb_pkg::OP_DIV_STEP: begin
        rem_q <= div_ge ? div_r - {1'b0, dvs_q} : div_r;
        quo_q <= {quo_q[46:0], div_ge};
      end
      rmsnfb_pkg::OP_SQRT_INIT: begin
        sv_q   <= 46'(quo_q[44:0]) + 46'(eps_i);
        root_q <= '0;
        bit_q  <= 46'h1 << 44;
      end
      rmsnfb_pkg::OP_SQRT_STEP: begin
        if (sv_q >= sq_trial) begin
          sv_q   <= sv_q - sq_trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      rmsnfb_pkg::OP_MUL: begin
        pl_q <= pl;
        ph_q <= ph;
      end
      rmsnfb_pkg::OP_MUL_SUM: begin
        case (cmd_i.step)
          rmsnfb_pkg::MS_T1G:   t1_q  <= p12[48:0];
          rmsnfb_pkg::MS_XMEAN: tmp_q <= p24[48:0];
          rmsnfb_pkg::MS_BINV:  tmp_q <= 49'(rmsnfb_pkg::sat40(p12));
          rmsnfb_pkg::MS_CINV:  t2_q  <= p12[55:0];
          rmsnfb_pkg::MS_GXINV: gw_q  <= rmsnfb_pkg::sat32(p12);
          rmsnfb_pkg::MS_YINV:  y_q   <= rmsnfb_pkg::sat32(p12);
          default:              tmp_q <= p12[48:0];
        endcase
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.op == rmsnfb_pkg::OP_EMIT) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rmsnfb_pkg::OP_EMIT) begin
      m_main_q  <= mode_i ? rmsnfb_pkg::sat32(gx_diff) : y_q;
      m_wgrad_q <= mode_i ? gw_q : 32'sd0;
      m_last_q  <= pass_last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_main_o  = m_main_q;
  assign m_wgrad_o = m_wgrad_q;
  assign m_last_o  = m_last_q;

  `RMSNFB_ASSERT(a_inv_nonzero, pass2_q |-> (inv_q != '0), "second pass with zero inverse rms")
  `RMSNFB_ASSERT_NEXT(a_emit_valid, cmd_i.op == rmsnfb_pkg::OP_EMIT, m_valid_q, "emitted word not valid")
  `RMSNFB_ASSERT_NEXT(a_last_clear, (cmd_i.op == rmsnfb_pkg::OP_EMIT) && pass_last, (!pass2_q && (cnt_q == '0)), "vector state not cleared after last word")

endmodule

>>> sv/rmsnorm_forward_backward_core.sv
// First pass: each word is accumulated; the last first-pass word then runs three
// 48-step divides on one shared divider and a 23-step square root.
// Second-pass word: 8 split multiplies backward, 2 forward, each a multiply then a sum.
// Output register: next word is accepted while a result waits on the master side.
// Reset (rst_ni low, async): accumulators, counters and pass flag clear; mode=1,
// vec_len=16, eps_term=168.
// ----------------------------------------------------------------------------
// RMSNorm forward/backward core
// Two-pass streaming fixed-point RMSNorm with config registers.
// ----------------------------------------------------------------------------
module rmsnorm_forward_backward_core #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // x_val[15:0], w_val[31:16], grad_val[47:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // main_out[31:0], weight_grad[63:32]
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_LEN  = 2'd1;
  localparam logic [1:0] REG_EPS  = 2'd2;

  logic        mode_q;
  logic [12:0] vec_len_q;
  logic [15:0] eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b1;
      vec_len_q <= 13'd16;
      eps_q     <= 16'd168;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE: mode_q    <= cfg_data_i[0];
        REG_LEN:  vec_len_q <= cfg_data_i[12:0];
        REG_EPS:  eps_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rmsnfb_pkg::cmd_t cmd;
  rmsnfb_pkg::sts_t sts;
  logic signed [31:0] main_w, wgrad_w;

  rmsnfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .mode_i     (mode_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmsnfb_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .x_i       (signed'(s_axis_tdata_i[15:0])),
    .w_i       (signed'(s_axis_tdata_i[31:16])),
    .g_i       (signed'(s_axis_tdata_i[47:32])),
    .mode_i    (mode_q),
    .vec_len_i (vec_len_q),
    .eps_i     (eps_q),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_main_o  (main_w),
    .m_wgrad_o (wgrad_w),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {wgrad_w, main_w};

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// RMSNorm core testbench
// Streams vectors twice through the core in both modes and several lengths,
// with bursty input and stalling output; checks every result word against
// a built-in fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxLen    = 4096;
  localparam int unsigned NumRandom = 1100;
  localparam int unsigned IdleWait  = 400;
  localparam int unsigned CycleCap  = 1000000;

  // register indexes
  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegVecLen = 2'd1;
  localparam logic [1:0] RegEps    = 2'd2;

  typedef struct packed {
    logic signed [15:0] grad;
    logic signed [15:0] w;
    logic signed [15:0] x;
  } elem_t;

  typedef struct packed {
    logic signed [31:0] main_out;
    logic signed [31:0] wgrad;
    logic               last;
  } res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  rmsnorm_forward_backward_core #(.MAX_LEN(MaxLen)) DUT (.*);

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic                mode_q;
  logic [12:0]         len_q;
  logic [15:0]         eps_q;
  logic [63:0]         sumsq;
  longint              mean_acc;
  longint              inv_rms;
  int                  elem_cnt;
  logic                pass2;

  res_t   results_due[$];
  int     mismatches;
  int     cycles;
  logic   out_stall_on;
  int     sent_items;

  function automatic longint sat_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint isqrt64(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic int norm_len();
    int l;
    l = len_q;
    if (l < 1) l = 1;
    if (l > MaxLen) l = MaxLen;
    return l;
  endfunction

  // advances the predictor by one element; pushes a result in pass two
  task automatic predict_norm(input elem_t e);
    longint x, w, g, t1, a, b, c, t2, ms, rms;
    int l;
    res_t r;
    x = e.x;
    w = e.w;
    g = e.grad;
    l = norm_len();
    if (!pass2) begin
      sumsq += 64'(x * x);
      mean_acc += ((g * w) >>> 12) * x;
      elem_cnt++;
      if (elem_cnt >= l) begin
        ms = longint'(sumsq / l) + eps_q;
        rms = isqrt64(ms);
        if (rms == 0) inv_rms = 64'hFF_FFFF;
        else inv_rms = sat_to((64'sd1 << 24) / rms, 0, 64'hFF_FFFF);
        mean_acc = mean_acc / l;
        elem_cnt = 0;
        pass2 = 1'b1;
      end
    end else begin
      if (!mode_q) begin
        r.main_out = 32'(sat_to(((((x * w) >>> 12) * inv_rms) >>> 12),
                                -64'sd2147483648, 64'sd2147483647));
        r.wgrad = '0;
      end else begin
        t1 = (((inv_rms * w) >>> 12) * g) >>> 12;
        a = (x * mean_acc) >>> 24;
        b = (a * inv_rms) >>> 12;
        c = sat_to((b * inv_rms) >>> 12, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
        t2 = (c * inv_rms) >>> 12;
        r.main_out = 32'(sat_to(t1 - t2, -64'sd2147483648, 64'sd2147483647));
        r.wgrad = 32'(sat_to((((g * x) >>> 12) * inv_rms) >>> 12,
                             -64'sd2147483648, 64'sd2147483647));
      end
      elem_cnt++;
      r.last = elem_cnt >= l;
      if (r.last) begin
        sumsq = 0;
        mean_acc = 0;
        inv_rms = 0;
        elem_cnt = 0;
        pass2 = 1'b0;
      end
      results_due.push_back(r);
    end
  endtask

  // output side: random stall pattern and compare
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      out_stall_on <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.main_out = m_axis_tdata_o[31:0];
        got.wgrad = m_axis_tdata_o[63:32];
        got.last = m_axis_tlast_o;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h last %b", m_axis_tdata_o,
                                         m_axis_tlast_o);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp main %0d wgrad %0d last %b, got %0d %0d %b",
                       want.main_out, want.wgrad, want.last,
                       got.main_out, got.wgrad, got.last);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) out_stall_on <= ~out_stall_on;
      m_axis_tready_i <= out_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMode:   mode_q = val[0];
      RegVecLen: len_q = val[12:0];
      default:   eps_q = val;
    endcase
  endtask

  int burst_left;

  // ends an open burst, then waits until every result is in and the core has settled
  task automatic drain();
    if (burst_left != 0) begin
      s_axis_tvalid_i <= 1'b0;
      burst_left = 0;
    end
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  // one word on the input stream, with bursts and gaps; valid is low when no burst is open
  task automatic send_elem(input elem_t e);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= e;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_norm(e);
    sent_items++;
    if (burst_left == 0) s_axis_tvalid_i <= 1'b0;
  endtask

  function automatic elem_t rand_elem(input int shape);
    elem_t e;
    e = 48'({$urandom, $urandom});
    // mostly modest magnitudes so results do not all saturate
    if (shape != 0) begin
      e.x = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      e.w = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      e.grad = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
    end
    return e;
  endfunction

  // vector sent twice, second pass identical to the first
  task automatic send_vector(input int n, input int shape);
    elem_t v[$];
    for (int i = 0; i < n; i++) v.push_back(rand_elem(shape));
    foreach (v[i]) send_elem(v[i]);
    foreach (v[i]) send_elem(v[i]);
  endtask

  // directed rows: grad, w, x
  elem_t edge_rows[16] = '{
    '{16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
    '{-16'sh8000, -16'sh8000, -16'sh8000},
    '{16'sh7FFF, -16'sh8000, 16'sh7FFF},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
    '{-16'sh8000, -16'sh8000, -16'sh8000},
    '{16'sh7FFF, -16'sh8000, 16'sh7FFF},
    '{16'sd4096, 16'sd4096, 16'sd4096},
    '{-16'sd1, 16'sd1, -16'sd1},
    '{16'sd4096, 16'sd4096, 16'sd4096},
    '{-16'sd1, 16'sd1, -16'sd1},
    '{16'sh5555, 16'shAAAA, 16'sh5555},
    '{16'shAAAA, 16'sh5555, 16'shAAAA},
    '{16'sh5555, 16'shAAAA, 16'sh5555},
    '{16'shAAAA, 16'sh5555, 16'shAAAA}
  };

  initial begin
    int lens[6];
    lens = '{1, 2, 3, 5, 8, 16};
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegMode;
    cfg_data_i = '0;
    sent_items = 0;
    burst_left = 0;
    mode_q = 1'b1;
    len_q = 13'd16;
    eps_q = 16'd168;
    sumsq = 0;
    mean_acc = 0;
    inv_rms = 0;
    elem_cnt = 0;
    pass2 = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset, length 1 with an all-zero vector: expect zero output
    write_reg(RegVecLen, 16'd1);
    write_reg(RegMode, 16'd0);
    send_elem(edge_rows[0]);
    send_elem(edge_rows[1]);
    drain();
    // zero rms with eps at its floor of the field: inverse saturates
    write_reg(RegEps, 16'd0);
    write_reg(RegMode, 16'd1);
    send_elem(edge_rows[0]);
    send_elem(edge_rows[1]);
    drain();
    // extremes in both modes, length 3 and 2
    write_reg(RegEps, 16'hFFFF);
    write_reg(RegVecLen, 16'd3);
    for (int i = 2; i < 8; i++) send_elem(edge_rows[i]);
    drain();
    write_reg(RegMode, 16'd0);
    write_reg(RegVecLen, 16'd2);
    for (int i = 8; i < 16; i++) send_elem(edge_rows[i]);
    drain();
    // length zero clamps to one
    write_reg(RegVecLen, 16'd0);
    write_reg(RegEps, 16'd1);
    send_vector(1, 1);
    drain();
    // length changed mid-vector (ends the pass early)
    write_reg(RegVecLen, 16'd6);
    for (int i = 0; i < 4; i++) send_elem(rand_elem(1));
    drain();
    write_reg(RegVecLen, 16'd3);
    for (int i = 0; i < 4; i++) send_elem(rand_elem(1));
    drain();

    // random phases
    while (sent_items < NumRandom) begin
      write_reg(RegMode, 16'($urandom_range(0, 1)));
      write_reg(RegVecLen, 16'(lens[$urandom_range(0, 5)]));
      write_reg(RegEps, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 400)));
      repeat ($urandom_range(2, 8)) send_vector(norm_len(), $urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) send_elem(rand_elem(0));
      drain();
    end

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> rmsnorm_forward_backward_core.f
+incdir+sv
sv/rmsnfb_pkg.sv
sv/rmsnfb_ctrl.sv
sv/rmsnfb_dp.sv
sv/rmsnorm_forward_backward_core.sv
verif/testbench.sv
